/* hw/rtl/ccp_pkg.sv */
// Shared types and constants for the certificate chain parser.
package ccp_pkg;

	localparam logic [7:0] CHAIN_VERSION = 8'd1;

	// Result queue sizing; one accepted byte pushes at most two records
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_VERSION = 2'd1,
		ST_SHORT = 2'd2,
		ST_TOO_LONG = 2'd3
	} ccp_status_t;

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_COUNT = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_DATA = 3'd4,
		PH_DONE = 3'd5
	} ccp_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_blob;
	} ccp_in_t;

	typedef struct packed {
		logic record_kind;
		logic [7:0] cert_index;
		logic [15:0] cert_offset;
		logic [15:0] data_len;
		logic [1:0] chain_status;
		logic [7:0] certs_found;
		logic final_result;
	} ccp_rec_t;

	// Records produced by one accepted byte, in delivery order
	typedef struct packed {
		logic [1:0] count;
		ccp_rec_t first;
		ccp_rec_t second;
	} ccp_push_t;

endpackage

/* hw/rtl/ccp_core.sv */
// Per-byte parse state and record generation.
module ccp_core (
	input logic clk,
	input logic arst_n,
	input logic take,
	input ccp_pkg::ccp_in_t byte_in,
	input logic [7:0] exp_version,
	output ccp_pkg::ccp_push_t push
);
	import ccp_pkg::*;

	ccp_phase_t phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic sticky_q, sticky_d;
	logic [7:0] ann_q, ann_d;
	logic [7:0] done_q, done_d;
	logic [7:0] lenhi_q, lenhi_d;
	logic [15:0] rem_q, rem_d;
	logic [15:0] start_q, start_d;
	logic err_q, err_d;

	logic [16:0] nxt;
	logic [15:0] rem_dec;
	logic [15:0] len_w;
	logic [7:0] done_inc;
	logic desc_v;
	ccp_rec_t desc, stat;
	ccp_status_t st;

	always_comb begin
		nxt = {1'b0, pos_q} + 17'd1;
		rem_dec = rem_q - 16'd1;
		len_w = {lenhi_q, byte_in.data_byte};
		done_inc = done_q + 8'd1;
		phase_d = phase_q;
		pos_d = pos_q;
		sticky_d = sticky_q;
		ann_d = ann_q;
		done_d = done_q;
		lenhi_d = lenhi_q;
		rem_d = rem_q;
		start_d = start_q;
		err_d = err_q;
		desc_v = 1'b0;
		desc = '0;
		stat = '0;
		st = ST_OK;
		push = '0;
		if (take) begin
			pos_d = nxt[15:0];
			sticky_d = sticky_q | nxt[16];
			case (phase_q)
				PH_VERSION: begin
					if (byte_in.data_byte != exp_version) begin
						err_d = 1'b1;
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					ann_d = byte_in.data_byte;
					phase_d = (byte_in.data_byte == 8'd0) ? PH_DONE : PH_LEN_HI;
				end
				PH_LEN_HI: begin
					lenhi_d = byte_in.data_byte;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					start_d = nxt[15:0];
					if (len_w == 16'd0) begin
						desc_v = 1'b1;
						desc.cert_offset = nxt[15:0];
						desc.data_len = 16'd0;
					end else begin
						rem_d = len_w;
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					rem_d = rem_dec;
					if (rem_dec == 16'd0) begin
						desc_v = 1'b1;
						desc.cert_offset = start_q;
						desc.data_len = nxt[15:0] - start_q;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase

			if (desc_v) begin
				desc.record_kind = KIND_DESC;
				desc.cert_index = done_q;
				desc.certs_found = ann_q;
				done_d = done_inc;
				phase_d = (done_inc == ann_q) ? PH_DONE : PH_LEN_HI;
			end

			// precedence: wrong version, too long, ended early
			if (err_d)
				st = ST_BAD_VERSION;
			else if (sticky_d)
				st = ST_TOO_LONG;
			else if (phase_d != PH_DONE)
				st = ST_SHORT;
			else
				st = ST_OK;
			stat.record_kind = KIND_STATUS;
			stat.chain_status = st;
			stat.certs_found = err_d ? 8'd0 : ann_d;
			stat.final_result = 1'b1;

			if (desc_v) begin
				push.first = desc;
				push.second = stat;
			end else begin
				push.first = stat;
			end
			push.count = {1'b0, desc_v} + {1'b0, byte_in.end_of_blob};

			if (byte_in.end_of_blob) begin
				phase_d = PH_VERSION;
				pos_d = '0;
				sticky_d = 1'b0;
				ann_d = '0;
				done_d = '0;
				lenhi_d = '0;
				rem_d = '0;
				start_d = '0;
				err_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION;
			pos_q <= '0;
			sticky_q <= 1'b0;
			ann_q <= '0;
			done_q <= '0;
			lenhi_q <= '0;
			rem_q <= '0;
			start_q <= '0;
			err_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			sticky_q <= sticky_d;
			ann_q <= ann_d;
			done_q <= done_d;
			lenhi_q <= lenhi_d;
			rem_q <= rem_d;
			start_q <= start_d;
			err_q <= err_d;
		end
	end

endmodule

/* hw/rtl/ccp_out_fifo.sv */
// Small queue: up to two records in, one out per cycle if rec_ready.
module ccp_out_fifo (
	input logic clk,
	input logic arst_n,
	input ccp_pkg::ccp_push_t push,
	output logic space_ok,
	output logic rec_valid,
	input logic rec_ready,
	output ccp_pkg::ccp_rec_t rec_data
);
	import ccp_pkg::*;

	ccp_rec_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, tail_p1;
	logic [CNT_W-1:0] count_q;
	logic pop;

	assign tail_p1 = tail_q + PTR_W'(1);
	assign pop = rec_valid && rec_ready;
	assign rec_valid = (count_q != '0);
	assign rec_data = mem_q[head_q];
	assign space_ok = (count_q <= CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[tail_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[tail_p1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + PTR_W'(1);
			tail_q <= tail_q + PTR_W'(push.count);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

/* hw/rtl/cert_chain_parser.sv */
// Top level of the certificate chain blob parser.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+--------------------------------
//  byte    | byte_valid| byte_ready| byte_data  (ccp_in_t)
//  rec     | rec_valid | rec_ready | rec_data   (ccp_rec_t)
//  cfg     | cfg_valid | cfg_ready | cfg_data   (expected version)
//
// One byte per cycle while byte_ready is high: the parse state updates in the
// accepting cycle and its records are registered into a four-entry result queue.
// A byte that ends a certificate on the end-of-blob mark pushes two records,
// drained one per cycle under rec_ready; byte_ready drops while fewer than two
// slots are free. Reset clears the parse state and queue and sets the expected
// version to 1. cfg_ready is always high.
module cert_chain_parser (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_ready,
	input ccp_pkg::ccp_in_t byte_data,
	output logic rec_valid,
	input logic rec_ready,
	output ccp_pkg::ccp_rec_t rec_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);
	import ccp_pkg::*;

	logic [7:0] exp_version_q;
	logic space_ok;
	logic take;
	ccp_push_t push;

	assign cfg_ready = 1'b1;
	assign byte_ready = space_ok;
	assign take = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_version_q <= CHAIN_VERSION;
		else if (cfg_valid && cfg_ready)
			exp_version_q <= cfg_data;
	end

	ccp_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.byte_in(byte_data),
		.exp_version(exp_version_q),
		.push(push)
	);

	ccp_out_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space_ok(space_ok),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec_data(rec_data)
	);

endmodule

/* hw/rtl/ccp_checker.sv */
// Port-level checks for the certificate chain parser, bound to the top level.
module ccp_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_ready,
	input ccp_pkg::ccp_in_t byte_data,
	input logic rec_valid,
	input logic rec_ready,
	input ccp_pkg::ccp_rec_t rec_data
);
	import ccp_pkg::*;

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_ready |=> rec_valid && $stable(rec_data))
		else $error("record changed while stalled");

	a_desc_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == KIND_DESC
		|-> !rec_data.final_result && rec_data.chain_status == ST_OK)
		else $error("descriptor carries status fields");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_data.record_kind == KIND_STATUS
		|-> rec_data.final_result && rec_data.cert_index == 8'd0
			&& rec_data.cert_offset == 16'd0 && rec_data.data_len == 16'd0
			&& (rec_data.chain_status != ST_BAD_VERSION || rec_data.certs_found == 8'd0))
		else $error("malformed status record");

	a_end_gives_rec: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready && byte_data.end_of_blob |=> rec_valid)
		else $error("no record after end of blob");

endmodule

bind cert_chain_parser ccp_checker u_ccp_checker (.*);
